/* design/rau_pkg.sv */
package rau_pkg;
  localparam int WIDTH = 32;
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL1, OP_MUL2, OP_COMBINE, OP_GCD_START, OP_GCD_STEP, OP_DIV_START, OP_DIV_STEP
  } op_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic combine;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_bus_t;

  typedef struct packed {
    logic skip_gcd;
    logic gcd_done;
    logic div_done;
  } stat_bus_t;
endpackage

/* design/rau_ctrl.sv */
module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_free,
  input  stat_bus_t stat,
  output cmd_bus_t  ctl,
  output logic      busy
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_COMB = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_GSET = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        ctl.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul2 = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        ctl.combine = 1'b1;
        state_next = S_GSET;
      end
      S_GSET: begin
        if (stat.skip_gcd) begin
          state_next = S_FIN;
        end else begin
          ctl.gcd_start = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          ctl.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          ctl.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_FIN;
        else ctl.div_step = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

/* design/rau_dp.sv */
module rau_dp
  import rau_pkg::*;
(
  input  logic              clk,
  input  cmd_bus_t          ctl,
  input  logic [2:0]        cmd,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output stat_bus_t         stat,
  output logic [31:0]       res_num,
  output logic [30:0]       res_den,
  output logic [4:0]        flags
);
  logic [2:0]  op;
  logic        a_neg, b_neg, a_ok, b_ok, rneg, dz;
  logic [31:0] an, ad, bn, bd;
  logic [63:0] p0, p1, p2;
  logic [63:0] rn, rd;
  logic [63:0] gx, gy;
  logic [6:0]  gsh;
  logic [6:0]  bitc;
  logic [63:0] qn, qd, rmn, rmd;
  logic        lt, eq, gt, ovf;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  logic in_cmp, in_red;
  assign in_cmp = (op == CMD_CMP);
  assign in_red = (op > CMD_CMP);

  logic [63:0] limit;
  assign limit = 64'd1 << (WIDTH - 1);

  logic [63:0] rmn_sh, rmd_sh;
  assign rmn_sh = {rmn[62:0], qn[63]};
  assign rmd_sh = {rmd[62:0], qd[63]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= cmd;
      a_ok <= (a_num == 0) || (a_den != 0);
      b_ok <= (b_num == 0) || (b_den != 0);
      a_neg <= (a_num != 0) && (a_num[31] != a_den[31]);
      b_neg <= (b_num != 0) && (b_num[31] != b_den[31]);
      an <= mag(a_num);
      ad <= (a_num == 0) ? 32'd1 : mag(a_den);
      bn <= mag(b_num);
      bd <= (b_num == 0) ? 32'd1 : mag(b_den);
    end
    if (ctl.mul1) begin
      p0 <= an * ((op == CMD_MUL) ? bn : bd);
      p2 <= ad * ((op == CMD_DIV) ? bn : bd);
    end
    if (ctl.mul2) p1 <= bn * ad;
    if (ctl.combine) begin
      logic bn2;
      bn2 = (op == CMD_SUB || op == CMD_CMP) ? !b_neg : b_neg;
      if (in_red) begin
        dz <= !a_ok;
        rn <= {32'd0, an};
        rd <= {32'd0, ad};
        rneg <= a_neg;
      end else if (!a_ok || !b_ok) begin
        dz <= 1'b1;
        rn <= '0;
        rd <= 64'd1;
        rneg <= 1'b0;
      end else if (op == CMD_MUL || op == CMD_DIV) begin
        rn <= p0;
        rd <= p2;
        rneg <= a_neg != b_neg;
        dz <= (op == CMD_DIV) && (p0 != 0) && (p2 == 0);
      end else begin
        rd <= p2;
        dz <= 1'b0;
        if (a_neg == bn2) begin
          rn <= p0 + p1;
          rneg <= a_neg;
        end else if (p0 >= p1) begin
          rn <= p0 - p1;
          rneg <= a_neg;
        end else begin
          rn <= p1 - p0;
          rneg <= bn2;
        end
      end
    end
    if (ctl.gcd_start) begin
      gx <= rn;
      gy <= rd;
      gsh <= '0;
    end
    if (ctl.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gsh <= gsh + 7'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx > gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
    if (ctl.div_start) begin
      gx <= gx << gsh;
      qn <= rn;
      qd <= rd;
      rmn <= '0;
      rmd <= '0;
      bitc <= 7'd64;
    end
    if (ctl.div_step) begin
      qn <= {qn[62:0], (rmn_sh >= gx)};
      qd <= {qd[62:0], (rmd_sh >= gx)};
      rmn <= (rmn_sh >= gx) ? rmn_sh - gx : rmn_sh;
      rmd <= (rmd_sh >= gx) ? rmd_sh - gx : rmd_sh;
      bitc <= bitc - 7'd1;
      if (bitc == 7'd1) begin
        rn <= {qn[62:0], (rmn_sh >= gx)};
        rd <= {qd[62:0], (rmd_sh >= gx)};
      end
    end
  end

  assign stat.skip_gcd = dz || (rn == 0);
  assign stat.gcd_done = (gx == gy);
  assign stat.div_done = (bitc == 0);

  always_comb begin
    eq = 1'b0; lt = 1'b0; gt = 1'b0; ovf = 1'b0;
    res_num = '0;
    res_den = 31'd1;
    if (!dz) begin
      if (in_cmp) begin
        eq = (rn == 0);
        lt = !eq && rneg;
        gt = !eq && !rneg;
      end
      if (rn == 0) begin
        res_num = '0;
        res_den = 31'd1;
      end else if (rd > limit - 64'd1 || rn > (rneg ? limit : limit - 64'd1)) begin
        ovf = 1'b1;
      end else begin
        res_num = rneg ? (32'd0 - rn[31:0]) : rn[31:0];
        res_den = rd[30:0];
      end
    end
    flags = {ovf, dz, gt, eq, lt};
  end
endmodule

/* design/rational_arithmetic_unit.sv */
// Flow: the operands are loaded, multiplied and combined; a zero or error result then goes
// straight to the output, otherwise the binary GCD loop and the 64-step restoring divide
// reduce the result first.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// loaded, and a stalled result holds the block.
// Reset: synchronous active-high rst returns the controller to idle and drops the result.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[62:32], less[63], equal[64], greater[65],
  // div_zero[66], overflow[67], zero fill
  output logic [71:0]  m_axis_tdata
);
  cmd_bus_t    ctl;
  stat_bus_t   stat;
  logic        busy, in_fire;
  logic [31:0] rnum;
  logic [30:0] rden;
  logic [4:0]  flags;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_axis_tvalid || m_axis_tready),
    .stat(stat), .ctl(ctl), .busy(busy)
  );

  rau_dp u_dp (
    .clk(clk), .ctl(ctl), .cmd(s_axis_tdata[2:0]),
    .a_num(s_axis_tdata[34:3]), .a_den(s_axis_tdata[66:35]),
    .b_num(s_axis_tdata[98:67]), .b_den(s_axis_tdata[130:99]),
    .stat(stat), .res_num(rnum), .res_den(rden), .flags(flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) m_axis_tdata <= {4'd0, flags, rden, rnum};
  end
endmodule

/* sim/rational_arithmetic_unit_tb.sv */
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam logic [2:0] CMD_RED = 3'd5;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } operands_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        less;
    logic        equal;
    logic        greater;
    logic        div_zero;
    logic        overflow;
  } quotient_t;

  typedef struct {
    bit          neg;
    logic [63:0] n;
    logic [63:0] d;
  } ratio_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  operands_t pending_ops[$];
  quotient_t expected_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  bit        hold_req = 0;
  bit        hold_taken = 0;
  bit        sent_now;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit load_ratio(logic [31:0] num, logic [31:0] den, output ratio_t f);
    logic signed [31:0] sn, sd;
    sn = num;
    sd = den;
    f.neg = 0; f.n = 0; f.d = 1;
    if (sn == 0) return 1;
    if (sd == 0) return 0;
    f.neg = (sn < 0) != (sd < 0);
    f.n = (sn < 0) ? 64'(-64'(sn)) : 64'(sn);
    f.d = (sd < 0) ? 64'(-64'(sd)) : 64'(sd);
    return 1;
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic ratio_t sum_ratio(ratio_t a, ratio_t b, bit sub);
    ratio_t r;
    logic [63:0] x, y;
    bit bneg;
    x = a.n * b.d;
    y = b.n * a.d;
    bneg = sub ? !b.neg : b.neg;
    r.d = a.d * b.d;
    if (a.neg == bneg) begin
      r.n = x + y; r.neg = a.neg;
    end else if (x >= y) begin
      r.n = x - y; r.neg = a.neg;
    end else begin
      r.n = y - x; r.neg = bneg;
    end
    return r;
  endfunction

  function automatic quotient_t rational_result(operands_t op);
    quotient_t q;
    ratio_t a, b, r;
    bit a_ok, b_ok, dz, ovf;
    logic [63:0] lim, g;
    a_ok = load_ratio(op.a_num, op.a_den, a);
    b_ok = load_ratio(op.b_num, op.b_den, b);
    r.neg = 0; r.n = 0; r.d = 1;
    dz = 0; ovf = 0;
    q = '{default: '0};
    q.res_den = 1;
    lim = 64'd1 << (WIDTH - 1);
    if (op.cmd >= CMD_RED) begin
      dz = !a_ok; r = a;
    end else if (!a_ok || !b_ok) begin
      dz = 1;
    end else if (op.cmd == CMD_ADD) begin
      r = sum_ratio(a, b, 0);
    end else if (op.cmd == CMD_SUB || op.cmd == CMD_CMP) begin
      r = sum_ratio(a, b, 1);
    end else if (op.cmd == CMD_MUL) begin
      r.neg = a.neg != b.neg; r.n = a.n * b.n; r.d = a.d * b.d;
    end else begin
      r.neg = a.neg != b.neg; r.n = a.n * b.d; r.d = a.d * b.n;
      if (r.n != 0 && r.d == 0) dz = 1;
    end
    if (!dz) begin
      if (r.n == 0) begin
        r.neg = 0; r.d = 1;
      end else begin
        g = euclid(r.n, r.d);
        r.n = r.n / g; r.d = r.d / g;
      end
      if (op.cmd == CMD_CMP) begin
        q.equal = (r.n == 0);
        q.less = !q.equal && r.neg;
        q.greater = !q.equal && !r.neg;
      end
      if (r.d > lim - 1 || r.n > (r.neg ? lim : lim - 1)) begin
        ovf = 1;
      end else begin
        q.res_num = r.neg ? 32'(-r.n) : 32'(r.n);
        q.res_den = 31'(r.d);
      end
    end
    q.div_zero = dz;
    q.overflow = ovf;
    return q;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'($urandom_range(0, 255)) * 32'($urandom_range(1, 64));
      4: return $urandom;
      5: return 32'(-int'($urandom_range(1, 4096)));
      default: return 32'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic queue_op(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    operands_t op;
    op.cmd = c; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    sent_now <= 0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_q.push_back(rational_result(pending_ops.pop_front()));
      sent_now <= 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || sent_now)) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, pending_ops[0].b_den, pending_ops[0].b_num,
                         pending_ops[0].a_den, pending_ops[0].a_num, pending_ops[0].cmd};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_off <= 600;
      hold_taken <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    quotient_t got, exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.res_num = m_axis_tdata[31:0];
      got.res_den = m_axis_tdata[62:32];
      got.less = m_axis_tdata[63];
      got.equal = m_axis_tdata[64];
      got.greater = m_axis_tdata[65];
      got.div_zero = m_axis_tdata[66];
      got.overflow = m_axis_tdata[67];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction %p", $time, got);
        errors <= errors + 1;
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp, got);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    int phase_pct[4][2];
    phase_pct = '{'{0, 0}, '{58, 0}, '{0, 58}, '{16, 16}};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    queue_op(CMD_ADD, 1, 2, 1, 3);
    queue_op(CMD_SUB, 1, 2, 1, 3);
    queue_op(CMD_SUB, 1, 3, 1, 2);
    queue_op(CMD_MUL, -2, 4, 3, -9);
    queue_op(CMD_DIV, 5, 7, 0, 0);
    queue_op(CMD_DIV, 0, 7, 0, 3);
    queue_op(CMD_DIV, 3, 7, 2, 5);
    queue_op(CMD_CMP, 1, 2, 2, 4);
    queue_op(CMD_CMP, -1, 2, 1, 3);
    queue_op(CMD_CMP, 32'h7fff_ffff, 1, -1, 1);
    queue_op(CMD_RED, 12, -18, 5, 0);
    queue_op(3'd6, 0, 0, 1, 0);
    queue_op(3'd7, 7, 0, 1, 1);
    queue_op(CMD_ADD, 3, 0, 1, 1);
    queue_op(CMD_MUL, 0, 0, 5, 0);
    queue_op(CMD_RED, 32'h8000_0000, -1, 0, 0);
    queue_op(CMD_RED, 32'h8000_0000, 1, 0, 0);
    queue_op(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    queue_op(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe, 32'h7fff_ffff);
    queue_op(CMD_DIV, 1, 32'h7fff_ffff, 32'h8000_0000, 1);
    queue_op(CMD_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_op(CMD_CMP, 5, 0, 1, 1);
    for (int i = 0; i < 730; i++) begin
      if (i % 183 == 0) begin
        wait_drained();
        send_idle_pct = phase_pct[i / 183][0];
        recv_stall_pct = phase_pct[i / 183][1];
        if (i == 183) hold_req = 1;
      end
      queue_op(3'($urandom_range(0, 7)), rand_field(), rand_field(), rand_field(),
               rand_field());
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* filelist.f */
design/rau_pkg.sv
design/rau_ctrl.sv
design/rau_dp.sv
design/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
